@@ rtl/core/bdc_pkg.sv @@
// Shared types and constants for the binary to decimal character cell block.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package bdc_pkg;

	localparam int VALUE_W  = 32;
	localparam int COORD_W  = 8;
	localparam int CHAR_W   = 6;
	localparam int DIGIT_W  = 4;
	localparam int NDIG_W   = 4;

	localparam int MAX_DIGITS = 10;
	localparam int CELL_WIDTH = 8;

	// A 32-bit value never has more than ten decimal digits.
	localparam int HARD_MAX = 10;
	localparam int DIG_CAP  = (MAX_DIGITS > HARD_MAX) ? HARD_MAX :
		((MAX_DIGITS < 1) ? 1 : MAX_DIGITS);

	localparam logic [CHAR_W-1:0] DIGIT_BASE = 6'h30;

	// floor(v / 10) == (v * RECIP10) >> RECIP_SHIFT for every 32-bit v.
	localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Thresholds 10, 100, ... 10^9 used to count the digits of a value.
	localparam int NPOW = 9;
	localparam logic [VALUE_W-1:0] POW10 [0:NPOW-1] = '{
		32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000,
		32'd10000000, 32'd100000000, 32'd1000000000
	};

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
		logic [NDIG_W-1:0]  ndig;
	} bdc_job_t;

	typedef struct packed {
		logic              busy;
		logic              step;
		logic [NDIG_W-1:0] left;
	} bdc_back_stat_t;

endpackage

@@ rtl/core/bdc_in_if.sv @@
// Input channel of the decimal character cell block: value, start column, row.
// Depends on bdc_pkg for the field widths.
`timescale 1ns / 1ps

interface bdc_in_if;
	logic                          valid;
	logic                          ready;
	logic [bdc_pkg::VALUE_W-1:0]   value;
	logic [bdc_pkg::COORD_W-1:0]   start_column;
	logic [bdc_pkg::COORD_W-1:0]   row;

	modport source (output valid, value, start_column, row, input ready);
	modport sink   (input valid, value, start_column, row, output ready);
endinterface

@@ rtl/core/bdc_out_if.sv @@
// Output channel of the decimal character cell block: one digit cell per beat.
// Depends on bdc_pkg for the field widths.
`timescale 1ns / 1ps

interface bdc_out_if;
	logic                          valid;
	logic                          ready;
	logic [bdc_pkg::CHAR_W-1:0]    char_code;
	logic [bdc_pkg::COORD_W-1:0]   cell_column;
	logic [bdc_pkg::COORD_W-1:0]   cell_row;
	logic                          last;

	modport source (output valid, char_code, cell_column, cell_row, last, input ready);
	modport sink   (input valid, char_code, cell_column, cell_row, last, output ready);
endinterface

@@ rtl/core/bdc_front.sv @@
// Front stage: takes input beats, counts the decimal digits and registers a job.
// Depends on bdc_pkg and bdc_in_if.
`timescale 1ns / 1ps

module bdc_front (
	input  logic              clk,
	input  logic              arst_n,
	bdc_in_if.sink            items,
	output logic              job_valid,
	input  logic              job_ready,
	output bdc_pkg::bdc_job_t job
);

	logic                        valid_s1;
	bdc_pkg::bdc_job_t           job_s1;
	logic [bdc_pkg::NDIG_W-1:0]  count;
	logic [bdc_pkg::NDIG_W-1:0]  ndig;
	logic                        accept;

	assign items.ready = !valid_s1 || job_ready;
	assign accept      = items.valid && items.ready;

	// The digit count is one plus the number of powers of ten not above the value.
	always_comb begin
		count = bdc_pkg::NDIG_W'(1);
		for (int i = 0; i < bdc_pkg::NPOW; i++) begin
			count = count + bdc_pkg::NDIG_W'(items.value >= bdc_pkg::POW10[i]);
		end
		if (count > bdc_pkg::NDIG_W'(bdc_pkg::DIG_CAP)) begin
			ndig = bdc_pkg::NDIG_W'(bdc_pkg::DIG_CAP);
		end else begin
			ndig = count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (job_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1.value  <= items.value;
			job_s1.column <= items.start_column;
			job_s1.row    <= items.row;
			job_s1.ndig   <= ndig;
		end
	end

	assign job_valid = valid_s1;
	assign job       = job_s1;

endmodule

@@ rtl/core/bdc_queue.sv @@
// Short job queue between the front and back stages.
// Depends on bdc_pkg for the job type and depth.
`timescale 1ns / 1ps

module bdc_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push_valid,
	output logic                       push_ready,
	input  bdc_pkg::bdc_job_t          push_data,
	output logic                       pop_valid,
	input  logic                       pop_ready,
	output bdc_pkg::bdc_job_t          pop_data,
	output logic [bdc_pkg::QCNT_W-1:0] count
);

	bdc_pkg::bdc_job_t                 slot_q [0:bdc_pkg::QDEPTH-1];
	logic [bdc_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [bdc_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [bdc_pkg::QCNT_W-1:0]        count_q;
	logic                              push;
	logic                              pop;

	assign push_ready = count_q != bdc_pkg::QCNT_W'(bdc_pkg::QDEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = slot_q[rd_ptr_q];
	assign count      = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == bdc_pkg::QPTR_W'(bdc_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == bdc_pkg::QPTR_W'(bdc_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ rtl/core/bdc_back.sv @@
// Back stage: splits a job into decimal digits into an output register, one per cycle while that register is not held.
// Depends on bdc_pkg and bdc_out_if.
`timescale 1ns / 1ps

module bdc_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   job_valid,
	output logic                   job_ready,
	input  bdc_pkg::bdc_job_t      job,
	bdc_out_if.source              digits,
	output bdc_pkg::bdc_back_stat_t stat
);

	logic                           busy_q;
	logic [bdc_pkg::NDIG_W-1:0]     left_q;
	logic [bdc_pkg::VALUE_W-1:0]    rem_q;
	logic [bdc_pkg::COORD_W-1:0]    col_q;
	logic [bdc_pkg::COORD_W-1:0]    row_q;

	logic                           out_valid_q;
	logic [bdc_pkg::CHAR_W-1:0]     out_char_q;
	logic [bdc_pkg::COORD_W-1:0]    out_col_q;
	logic [bdc_pkg::COORD_W-1:0]    out_row_q;
	logic                           out_last_q;

	logic                           step;
	logic                           final_digit;
	logic                           pop;
	logic [2*bdc_pkg::VALUE_W-1:0]  prod;
	logic [bdc_pkg::VALUE_W-1:0]    quot;
	logic [bdc_pkg::VALUE_W-1:0]    times10;
	logic [bdc_pkg::VALUE_W-1:0]    rem_full;
	logic [bdc_pkg::NDIG_W-1:0]     pos;
	logic [bdc_pkg::COORD_W-1:0]    offset;

	assign step        = busy_q && (!out_valid_q || digits.ready);
	assign final_digit = left_q == bdc_pkg::NDIG_W'(1);
	assign job_ready   = !busy_q || (step && final_digit);
	assign pop         = job_valid && job_ready;

	// Divide by ten through the reciprocal; the quotient is below 2^29.
	always_comb begin
		prod     = {{bdc_pkg::VALUE_W{1'b0}}, rem_q} *
			{{bdc_pkg::VALUE_W{1'b0}}, bdc_pkg::RECIP10};
		quot     = bdc_pkg::VALUE_W'(prod[2*bdc_pkg::VALUE_W-1:bdc_pkg::RECIP_SHIFT]);
		times10  = {quot[bdc_pkg::VALUE_W-4:0], 3'b000} + {quot[bdc_pkg::VALUE_W-2:0], 1'b0};
		rem_full = rem_q - times10;
		pos      = left_q - 1'b1;
		offset   = bdc_pkg::COORD_W'(pos) * bdc_pkg::COORD_W'(bdc_pkg::CELL_WIDTH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				left_q <= job.ndig;
			end else if (step) begin
				busy_q <= !final_digit;
				left_q <= pos;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (digits.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rem_q <= job.value;
			col_q <= job.column;
			row_q <= job.row;
		end else if (step) begin
			rem_q <= quot;
		end
		if (step) begin
			out_char_q <= bdc_pkg::DIGIT_BASE +
				bdc_pkg::CHAR_W'(rem_full[bdc_pkg::DIGIT_W-1:0]);
			out_col_q  <= col_q + offset;
			out_row_q  <= row_q;
			out_last_q <= final_digit;
		end
	end

	assign digits.valid       = out_valid_q;
	assign digits.char_code   = out_char_q;
	assign digits.cell_column = out_col_q;
	assign digits.cell_row    = out_row_q;
	assign digits.last        = out_last_q;

	assign stat.busy = busy_q;
	assign stat.step = step;
	assign stat.left = left_q;

endmodule

@@ rtl/core/binary_to_decimal_char_cells.sv @@
// Top level of the binary to decimal character cell block.
// Depends on bdc_pkg, bdc_in_if, bdc_out_if, bdc_front, bdc_queue and bdc_back.
//
// Usage: each beat on the items channel carries an unsigned 32-bit value, the
// pixel column of its leftmost character cell and a row. For every value the
// digits channel returns one beat per decimal digit, least significant first,
// with the ASCII code, the cell column (start plus eight pixels per position
// from the left, modulo 256) and the row; last is set on the most significant
// digit. A zero value gives a single '0' beat at the start column.
// An input beat passes the front job register and the job queue before the back
// stage puts its first digit in the digit register. For a value of 1 to 10
// digits it gives one digit per cycle from its divide-by-ten multiplier
// while the digit register is not held, and takes the next job with the final
// digit. The front stage and a two-entry job queue accept values as it works.
// Reset clears all handshake state; no clearing pass is needed. When the
// receiver holds ready low the digit register holds its beat, the back stage
// waits, and the queue then the items ready fill up and back-pressure the source.
`timescale 1ns / 1ps

module binary_to_decimal_char_cells (
	input  logic      clk,
	input  logic      arst_n,
	bdc_in_if.sink    items,
	bdc_out_if.source digits
);

	logic                          f_valid;
	logic                          f_ready;
	bdc_pkg::bdc_job_t             f_job;
	logic                          b_valid;
	logic                          b_ready;
	bdc_pkg::bdc_job_t             b_job;
	logic [bdc_pkg::QCNT_W-1:0]    q_count;
	bdc_pkg::bdc_back_stat_t       b_stat;

	bdc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.job_valid (f_valid),
		.job_ready (f_ready),
		.job       (f_job)
	);

	bdc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_job),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_job),
		.count      (q_count)
	);

	bdc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (b_valid),
		.job_ready (b_ready),
		.job       (b_job),
		.digits    (digits),
		.stat      (b_stat)
	);

	// A busy back stage always has between one and the cap of digits to go.
	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		b_stat.busy |-> (b_stat.left != '0 &&
			b_stat.left <= bdc_pkg::NDIG_W'(bdc_pkg::DIG_CAP)))
		else $error("back stage busy with a bad digit count");

	// The queue never holds more jobs than it has slots.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= bdc_pkg::QCNT_W'(bdc_pkg::QDEPTH))
		else $error("job queue overflow");

	// Producing the final digit of a job must put a beat marked last out.
	a_last_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(b_stat.step && b_stat.left == bdc_pkg::NDIG_W'(1)) |=> (digits.valid && digits.last))
		else $error("final digit beat not marked last");

	// A digit beat not marked last means the back stage still has the job.
	a_more_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(digits.valid && !digits.last) |-> b_stat.busy)
		else $error("digit beat without last while back stage idle");

endmodule

@@ test/tb_binary_to_decimal_char_cells.sv @@
// Testbench for binary_to_decimal_char_cells: directed and random numbers, checked per digit
// against a predictor or a hand-written cell; random idling on both channels, long stalls on the receiver.
// Depends on bdc_pkg, bdc_in_if, bdc_out_if and the block's RTL.
`timescale 1ns / 1ps

module tb_binary_to_decimal_char_cells;

	localparam int HOLD_CYCLES    = 64;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int MAX_SHOWN      = 10;
	localparam int IDLE_PERCENT   = 7;

	localparam logic [bdc_pkg::CHAR_W-1:0] CHAR_ZERO = bdc_pkg::DIGIT_BASE;

	typedef struct packed {
		logic [bdc_pkg::CHAR_W-1:0]  char_code;
		logic [bdc_pkg::COORD_W-1:0] column;
		logic [bdc_pkg::COORD_W-1:0] row;
		logic                        last;
	} digit_cell_t;

	// A number to convert; typed rows carry their single digit cell written out by hand.
	typedef struct packed {
		logic [bdc_pkg::VALUE_W-1:0] value;
		logic [bdc_pkg::COORD_W-1:0] column;
		logic [bdc_pkg::COORD_W-1:0] row;
		logic                        typed;
		digit_cell_t                 typed_cell;
	} number_row_t;

	localparam int N_DIRECTED = 18;
	localparam number_row_t DIRECTED [N_DIRECTED] = '{
		'{32'd0,          8'd0,   8'd0,   1'b1, '{CHAR_ZERO,         8'd0,   8'd0,   1'b1}},
		'{32'd0,          8'd255, 8'd255, 1'b1, '{CHAR_ZERO,         8'd255, 8'd255, 1'b1}},
		'{32'd9,          8'd17,  8'd3,   1'b1, '{CHAR_ZERO + 6'd9,  8'd17,  8'd3,   1'b1}},
		'{32'd1,          8'd250, 8'd128, 1'b1, '{CHAR_ZERO + 6'd1,  8'd250, 8'd128, 1'b1}},
		'{32'd10,         8'd0,   8'd0,   1'b0, '0},
		'{32'd99,         8'd255, 8'd255, 1'b0, '0},
		'{32'd100,        8'd252, 8'd7,   1'b0, '0},
		'{32'hFFFF_FFFF,  8'd0,   8'd0,   1'b0, '0},
		'{32'hFFFF_FFFF,  8'd255, 8'd255, 1'b0, '0},
		'{32'hFFFF_FFFF,  8'd200, 8'd64,  1'b0, '0},
		'{32'd1000000000, 8'd8,   8'd1,   1'b0, '0},
		'{32'd999999999,  8'd0,   8'd254, 1'b0, '0},
		'{32'h8000_0000,  8'd128, 8'd127, 1'b0, '0},
		'{32'hAAAA_AAAA,  8'd85,  8'd170, 1'b0, '0},
		'{32'h5555_5555,  8'd170, 8'd85,  1'b0, '0},
		'{32'd12345,      8'd240, 8'd33,  1'b0, '0},
		'{32'd1000000,    8'd3,   8'd200, 1'b0, '0},
		'{32'hFFFF_FFFE,  8'd1,   8'd2,   1'b0, '0}
	};

	logic clk;
	logic arst_n;

	bdc_in_if  items_if ();
	bdc_out_if digits_if ();

	binary_to_decimal_char_cells dut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items_if.sink),
		.digits (digits_if.source)
	);

	digit_cell_t pending_cells [$];
	number_row_t offered_numbers [$];
	int          mismatches;
	int          quiet_cycles;
	bit          steady;
	bit          hold_off_req;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Queue the digit cells of one number, least significant digit first.
	function automatic void queue_digit_cells(input logic [31:0] value,
		input logic [7:0] column, input logic [7:0] row);
		logic [31:0] rest;
		int          ndig;
		int          cap;
		int          pos;
		digit_cell_t entry;
		rest = value;
		ndig = 1;
		while (rest >= 32'd10) begin
			rest = rest / 32'd10;
			ndig++;
		end
		cap = (bdc_pkg::MAX_DIGITS > 10) ? 10 :
			((bdc_pkg::MAX_DIGITS < 1) ? 1 : bdc_pkg::MAX_DIGITS);
		if (ndig > cap)
			ndig = cap;
		rest = value;
		for (pos = ndig - 1; pos >= 0; pos--) begin
			entry.char_code = CHAR_ZERO + 6'(rest % 32'd10);
			entry.column    = column + 8'(bdc_pkg::CELL_WIDTH * pos);
			entry.row       = row;
			entry.last      = (pos == 0);
			pending_cells.push_back(entry);
			rest = rest / 32'd10;
		end
	endfunction

	function automatic void report_mismatch(input string what, input digit_cell_t want,
		input digit_cell_t got);
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("%0t: %s: expected char %h col %0d row %0d last %b, ",
				"got char %h col %0d row %0d last %b",
				$realtime, what, want.char_code, want.column, want.row, want.last,
				got.char_code, got.column, got.row, got.last);
	endfunction

	// Draws a value whose digit count is spread evenly, with some zeros and raw words.
	function automatic logic [31:0] draw_value();
		int          pick;
		int          ndig;
		logic [63:0] lo;
		logic [63:0] hi;
		pick = $urandom_range(99);
		if (pick < 12)
			return $urandom;
		if (pick < 17)
			return 32'd0;
		ndig = $urandom_range(10, 1);
		lo = 64'd1;
		repeat (ndig - 1) lo = lo * 64'd10;
		hi = lo * 64'd10 - 64'd1;
		if (ndig == 1)
			lo = 64'd0;
		if (hi > 64'hFFFF_FFFF)
			hi = 64'hFFFF_FFFF;
		return 32'(lo + ({32'd0, $urandom} % (hi - lo + 64'd1)));
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_number(input number_row_t num);
		while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			items_if.valid <= 1'b0;
			@(negedge clk);
		end
		items_if.valid        <= 1'b1;
		items_if.value        <= num.value;
		items_if.start_column <= num.column;
		items_if.row          <= num.row;
		offered_numbers.push_back(num);
		@(posedge clk);
		while (!items_if.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random(input int count);
		number_row_t num;
		repeat (count) begin
			num.value  = draw_value();
			num.column = 8'($urandom);
			num.row    = 8'($urandom);
			num.typed  = 1'b0;
			num.typed_cell = '0;
			send_number(num);
		end
	endtask

	// Lowers valid and waits for every digit in flight to come out.
	task automatic pause_until_drained();
		items_if.valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_cells.size() != 0);
	endtask

	// Receiver: random ready, plus one long counted hold-off on request.
	initial begin
		digits_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				digits_if.ready <= 1'b0;
				for (int i = 0; i < HOLD_CYCLES; i++)
					@(negedge clk);
				hold_off_req = 1'b0;
				digits_if.ready <= 1'b1;
			end else begin
				digits_if.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	always @(posedge clk) begin
		digit_cell_t got;
		digit_cell_t want;
		number_row_t num;
		logic        moved;
		moved = 1'b0;
		if (arst_n) begin
			if (items_if.valid && items_if.ready) begin
				moved = 1'b1;
				num = offered_numbers.pop_front();
				if (num.typed)
					pending_cells.push_back(num.typed_cell);
				else
					queue_digit_cells(num.value, num.column, num.row);
			end
			if (digits_if.valid && digits_if.ready) begin
				moved = 1'b1;
				got = '{digits_if.char_code, digits_if.cell_column, digits_if.cell_row,
					digits_if.last};
				if (pending_cells.size() == 0) begin
					report_mismatch("digit beat with nothing expected", '0, got);
				end else begin
					want = pending_cells.pop_front();
					if (got.char_code !== want.char_code || got.column !== want.column ||
						got.row !== want.row || got.last !== want.last)
						report_mismatch("digit cell mismatch", want, got);
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		mismatches   = 0;
		quiet_cycles = 0;
		steady       = 1'b0;
		hold_off_req = 1'b0;
		items_if.valid        = 1'b0;
		items_if.value        = '0;
		items_if.start_column = '0;
		items_if.row          = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_number(DIRECTED[i]);
		pause_until_drained();

		// The receiver stalls for a long stretch while numbers keep coming.
		hold_off_req = 1'b1;
		send_random(100);
		pause_until_drained();

		steady = 1'b1;
		send_random(100);
		steady = 1'b0;
		hold_off_req = 1'b1;
		send_random(120);

		pause_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_cells.size() == 0 && offered_numbers.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/bdc_pkg.sv
rtl/core/bdc_in_if.sv
rtl/core/bdc_out_if.sv
rtl/core/bdc_front.sv
rtl/core/bdc_queue.sv
rtl/core/bdc_back.sv
rtl/core/binary_to_decimal_char_cells.sv
test/tb_binary_to_decimal_char_cells.sv
